// ===== hdl/esl_pkg.sv =====
package esl_pkg;

  // LED blink timing
  localparam int BLINK_HALF_MS     = 100;
  localparam int BLINK_PERIOD_MS   = 2 * BLINK_HALF_MS;
  localparam int PENDING_PERIOD_MS = 200;
  localparam int PENDING_ON_MS     = 100;
  localparam int BLINK_PH_W        = $clog2(BLINK_PERIOD_MS);
  localparam int PEND_PH_W         = $clog2(PENDING_PERIOD_MS);

  // configuration register reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd50;
  localparam logic [15:0] RELEASE_RST  = 16'd1000;
  localparam logic [15:0] STUCK_RST    = 16'd5000;

  // configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [1:0] CFG_RELEASE  = 2'd1;
  localparam logic [1:0] CFG_STUCK    = 2'd2;

  localparam logic [2:0] SRC_BUTTON = 3'd0;

  typedef enum logic [1:0] {
    MODE_ARMED     = 2'd0,
    MODE_TRIGGERED = 2'd1,
    MODE_PENDING   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_TRIGGER     = 2'd1,
    OP_RESET_REQ   = 2'd2,
    OP_BUTTON_EDGE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_NOT_TRIGGERED = 2'd1,
    STATUS_PRESSED       = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] release_delay_ms;
    logic [15:0] stuck_timeout_ms;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic       pressed;
    logic [2:0] source;
  } item_t;

  typedef struct packed {
    mode_t                 mode;
    logic [31:0]           now_ms;
    logic [31:0]           entry_time;
    logic [31:0]           press_start;
    logic                  debounced;
    logic                  relay;
    logic                  led;
    logic [2:0]            source;
    logic [31:0]           trig_total;
    logic [31:0]           trig_stamp;
    logic [BLINK_PH_W-1:0] blink_ph;   // now_ms mod BLINK_PERIOD_MS
    logic [PEND_PH_W-1:0]  pend_ph;    // now_ms mod PENDING_PERIOD_MS
  } state_t;

  typedef struct packed {
    status_t     status;
    mode_t       mode;
    logic        relays_on;
    logic        led_on;
    logic        press_debounced;
    logic [2:0]  trigger_source;
    logic [31:0] trigger_total;
    logic [31:0] trigger_stamp;
    logic        health;
  } result_t;

endpackage

// ===== hdl/esl_step.sv =====
module esl_step (
  input  esl_pkg::state_t  st,
  input  esl_pkg::cfg_t    cfg,
  input  esl_pkg::item_t   item,
  output esl_pkg::state_t  st_nxt,
  output esl_pkg::result_t res
);

  logic [31:0]                    tick_now;
  logic [esl_pkg::BLINK_PH_W-1:0] blink_ph_n;
  logic [esl_pkg::PEND_PH_W-1:0]  pend_ph_n;
  logic                           latch;
  logic [2:0]                     latch_src;
  logic [31:0]                    latch_time;

  assign tick_now = st.now_ms + 32'd1;

  // phase counters restart when the 32-bit clock wraps, as the modulo would
  always_comb begin
    if (tick_now == 32'd0 ||
        st.blink_ph == esl_pkg::BLINK_PH_W'(esl_pkg::BLINK_PERIOD_MS - 1)) begin
      blink_ph_n = '0;
    end else begin
      blink_ph_n = st.blink_ph + esl_pkg::BLINK_PH_W'(1);
    end
    if (tick_now == 32'd0 ||
        st.pend_ph == esl_pkg::PEND_PH_W'(esl_pkg::PENDING_PERIOD_MS - 1)) begin
      pend_ph_n = '0;
    end else begin
      pend_ph_n = st.pend_ph + esl_pkg::PEND_PH_W'(1);
    end
  end

  always_comb begin
    st_nxt     = st;
    res.status = esl_pkg::STATUS_OK;
    latch      = 1'b0;
    latch_src  = item.source;
    latch_time = st.now_ms;

    case (item.op)
      esl_pkg::OP_TICK: begin
        st_nxt.now_ms   = tick_now;
        st_nxt.blink_ph = blink_ph_n;
        st_nxt.pend_ph  = pend_ph_n;
        if (item.pressed) begin
          if ((tick_now - st.press_start) > {16'd0, cfg.debounce_ms}) begin
            st_nxt.debounced = 1'b1;
          end
        end else begin
          st_nxt.debounced   = 1'b0;
          st_nxt.press_start = tick_now;
        end
        case (st.mode)
          esl_pkg::MODE_ARMED: begin
            if (st_nxt.debounced) begin
              latch      = 1'b1;
              latch_src  = esl_pkg::SRC_BUTTON;
              latch_time = tick_now;
            end
          end
          esl_pkg::MODE_PENDING: begin
            if ((tick_now - st.entry_time) > {16'd0, cfg.release_delay_ms}) begin
              st_nxt.relay      = 1'b0;
              st_nxt.mode       = esl_pkg::MODE_ARMED;
              st_nxt.entry_time = tick_now;
            end
          end
          default: ;
        endcase
      end
      esl_pkg::OP_TRIGGER: begin
        latch = 1'b1;
      end
      esl_pkg::OP_RESET_REQ: begin
        if (st.mode != esl_pkg::MODE_TRIGGERED) begin
          res.status = esl_pkg::STATUS_NOT_TRIGGERED;
        end else if (item.pressed) begin
          res.status = esl_pkg::STATUS_PRESSED;
        end else begin
          st_nxt.mode       = esl_pkg::MODE_PENDING;
          st_nxt.entry_time = st.now_ms;
        end
      end
      esl_pkg::OP_BUTTON_EDGE: begin
        st_nxt.press_start = st.now_ms;
      end
      default: ;
    endcase

    if (latch) begin
      st_nxt.source     = latch_src;
      st_nxt.trig_total = st.trig_total + 32'd1;
      st_nxt.trig_stamp = latch_time;
      st_nxt.relay      = 1'b1;
      st_nxt.mode       = esl_pkg::MODE_TRIGGERED;
      st_nxt.entry_time = latch_time;
    end

    // LED follows the mode only on a tick
    if (item.op == esl_pkg::OP_TICK) begin
      case (st_nxt.mode)
        esl_pkg::MODE_ARMED:
          st_nxt.led = (blink_ph_n < esl_pkg::BLINK_PH_W'(esl_pkg::BLINK_HALF_MS));
        esl_pkg::MODE_TRIGGERED:
          st_nxt.led = 1'b1;
        esl_pkg::MODE_PENDING:
          st_nxt.led = (pend_ph_n < esl_pkg::PEND_PH_W'(esl_pkg::PENDING_ON_MS));
        default:
          st_nxt.led = 1'b0;
      endcase
    end

    res.mode            = st_nxt.mode;
    res.relays_on       = st_nxt.relay;
    res.led_on          = st_nxt.led;
    res.press_debounced = st_nxt.debounced;
    res.trigger_source  = st_nxt.source;
    res.trigger_total   = st_nxt.trig_total;
    res.trigger_stamp   = st_nxt.trig_stamp;
    res.health          = (st_nxt.mode == esl_pkg::MODE_PENDING) &&
                          ((st_nxt.now_ms - st_nxt.entry_time) >
                           {16'd0, cfg.stuck_timeout_ms});
  end

endmodule

// ===== hdl/emergency_stop_latch_controller.sv =====
// Emergency stop latch. Every request on the in_ channel (tick, external
// trigger, reset request or button edge) yields exactly one result on the
// out_ channel, showing the latch state after that request. A new request is
// taken every clock cycle while in_stall is low; a request passes an input
// register and one step of next-state logic into the result register, which
// drives out_. in_stall rises only while a result is held by out_stall and
// the input register is full.
// cfg_ready is always high; writes take effect on the next request, and
// writes to an index beyond the register list are ignored.
module emergency_stop_latch_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic        in_button_pressed,
  input  logic [2:0]  in_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_mode,
  output logic        out_relays_on,
  output logic        out_led_on,
  output logic        out_press_debounced,
  output logic [2:0]  out_trigger_source,
  output logic [31:0] out_trigger_total,
  output logic [31:0] out_trigger_stamp,
  output logic        out_health,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  esl_pkg::cfg_t    cfg_r;
  esl_pkg::state_t  st_r;
  esl_pkg::state_t  st_nxt;
  esl_pkg::item_t   item_r;
  esl_pkg::result_t res_nxt;
  esl_pkg::result_t res_r;
  logic             in_valid_r;
  logic             out_valid_r;
  logic             advance;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms      <= esl_pkg::DEBOUNCE_RST;
      cfg_r.release_delay_ms <= esl_pkg::RELEASE_RST;
      cfg_r.stuck_timeout_ms <= esl_pkg::STUCK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        esl_pkg::CFG_DEBOUNCE: cfg_r.debounce_ms      <= cfg_data;
        esl_pkg::CFG_RELEASE:  cfg_r.release_delay_ms <= cfg_data;
        esl_pkg::CFG_STUCK:    cfg_r.stuck_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.op      <= esl_pkg::op_t'(in_op);
      item_r.pressed <= in_button_pressed;
      item_r.source  <= in_source;
    end
  end

  esl_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_valid_r && advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = res_r.status;
  assign out_mode            = res_r.mode;
  assign out_relays_on       = res_r.relays_on;
  assign out_led_on          = res_r.led_on;
  assign out_press_debounced = res_r.press_debounced;
  assign out_trigger_source  = res_r.trigger_source;
  assign out_trigger_total   = res_r.trigger_total;
  assign out_trigger_stamp   = res_r.trigger_stamp;
  assign out_health          = res_r.health;

endmodule

// ===== hdl/esl_checker.sv =====
module esl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [1:0]  out_mode,
  input logic        out_relays_on,
  input logic [31:0] out_trigger_total,
  input logic        out_health
);

  // a held result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_trigger_total) &&
      $stable(out_mode) && $stable(out_status))
    else $error("result changed while stalled");

  // backpressure only ever comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // relays are energized in every mode but armed
  a_relay_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_relays_on == (out_mode != esl_pkg::MODE_ARMED))
    else $error("relay drive disagrees with mode");

  // a refused reset leaves the mode that caused the refusal
  a_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == esl_pkg::STATUS_PRESSED |->
      out_mode == esl_pkg::MODE_TRIGGERED)
    else $error("pressed refusal outside triggered");

  a_health: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_health |-> out_mode == esl_pkg::MODE_PENDING)
    else $error("health fault outside reset pending");

endmodule

bind emergency_stop_latch_controller esl_checker u_esl_checker (.*);

// ===== tb/emergency_stop_latch_controller_tb.sv =====
`timescale 1ns / 100ps

module emergency_stop_latch_controller_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] CFG_SPARE = 2'd3;  // no register here, writes are dropped

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = esl_pkg::OP_TICK;
  logic        in_button_pressed = 1'b0;
  logic [2:0]  in_source = esl_pkg::SRC_BUTTON;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [1:0]  out_mode;
  logic        out_relays_on;
  logic        out_led_on;
  logic        out_press_debounced;
  logic [2:0]  out_trigger_source;
  logic [31:0] out_trigger_total;
  logic [31:0] out_trigger_stamp;
  logic        out_health;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = esl_pkg::CFG_DEBOUNCE;
  logic [15:0] cfg_data = 16'd0;

  // latch model state
  esl_pkg::mode_t latch_mode;
  logic [31:0]    clk_ms;
  logic [31:0]    mode_since;
  logic [31:0]    press_since;
  logic           press_ok;
  logic           relay_drive;
  logic           led_drive;
  logic [2:0]     trip_src;
  logic [31:0]    trips;
  logic [31:0]    trip_ms;
  logic [15:0]    debounce_lim;
  logic [15:0]    release_lim;
  logic [15:0]    stuck_lim;

  esl_pkg::result_t expected_results[$];
  int      fails = 0;
  int      hold_cycles = 0;
  bit      calm = 1'b0;
  bit      sender_idles = 1'b1;

  emergency_stop_latch_controller dut (.*);

  always #6 clk = ~clk;

  function automatic void reset_latch_model();
    latch_mode   = esl_pkg::MODE_ARMED;
    clk_ms       = '0;
    mode_since   = '0;
    press_since  = '0;
    press_ok     = 1'b0;
    relay_drive  = 1'b0;
    led_drive    = 1'b0;
    trip_src     = esl_pkg::SRC_BUTTON;
    trips        = '0;
    trip_ms      = '0;
    debounce_lim = esl_pkg::DEBOUNCE_RST;
    release_lim  = esl_pkg::RELEASE_RST;
    stuck_lim    = esl_pkg::STUCK_RST;
  endfunction

  function automatic void trip_latch(logic [2:0] src);
    trip_src    = src;
    trips       = trips + 32'd1;
    trip_ms     = clk_ms;
    relay_drive = 1'b1;
    latch_mode  = esl_pkg::MODE_TRIGGERED;
    mode_since  = clk_ms;
  endfunction

  function automatic esl_pkg::result_t latch_step(esl_pkg::op_t op, logic pressed,
                                                  logic [2:0] src);
    esl_pkg::result_t r;
    logic [31:0]      held_ms;
    logic [31:0]      pend_ms;
    r = '0;
    r.status = esl_pkg::STATUS_OK;
    case (op)
      esl_pkg::OP_TICK: begin
        clk_ms = clk_ms + 32'd1;
        held_ms = clk_ms - press_since;
        if (!pressed) begin
          press_ok = 1'b0;
          press_since = clk_ms;
        end else if (held_ms > {16'd0, debounce_lim}) begin
          press_ok = 1'b1;
        end
        pend_ms = clk_ms - mode_since;
        if (latch_mode == esl_pkg::MODE_ARMED) begin
          if (press_ok) trip_latch(esl_pkg::SRC_BUTTON);
        end else if (latch_mode == esl_pkg::MODE_PENDING) begin
          if (pend_ms > {16'd0, release_lim}) begin
            relay_drive = 1'b0;
            latch_mode = esl_pkg::MODE_ARMED;
            mode_since = clk_ms;
          end
        end
        case (latch_mode)
          esl_pkg::MODE_ARMED:
            led_drive = (clk_ms % esl_pkg::BLINK_PERIOD_MS) < esl_pkg::BLINK_HALF_MS;
          esl_pkg::MODE_TRIGGERED:
            led_drive = 1'b1;
          esl_pkg::MODE_PENDING:
            led_drive = (clk_ms % esl_pkg::PENDING_PERIOD_MS) < esl_pkg::PENDING_ON_MS;
          default:
            led_drive = 1'b0;
        endcase
      end
      esl_pkg::OP_TRIGGER: trip_latch(src);
      esl_pkg::OP_RESET_REQ: begin
        if (latch_mode != esl_pkg::MODE_TRIGGERED) r.status = esl_pkg::STATUS_NOT_TRIGGERED;
        else if (pressed) r.status = esl_pkg::STATUS_PRESSED;
        else begin
          latch_mode = esl_pkg::MODE_PENDING;
          mode_since = clk_ms;
        end
      end
      esl_pkg::OP_BUTTON_EDGE: press_since = clk_ms;
      default: ;
    endcase
    pend_ms = clk_ms - mode_since;
    r.mode            = latch_mode;
    r.relays_on       = relay_drive;
    r.led_on          = led_drive;
    r.press_debounced = press_ok;
    r.trigger_source  = trip_src;
    r.trigger_total   = trips;
    r.trigger_stamp   = trip_ms;
    r.health          = (latch_mode == esl_pkg::MODE_PENDING) &&
                        (pend_ms > {16'd0, stuck_lim});
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    esl_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding (mode %0d)", out_mode);
        fails++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, out_status);
        check_field("mode", want.mode, out_mode);
        check_field("relays_on", want.relays_on, out_relays_on);
        check_field("led_on", want.led_on, out_led_on);
        check_field("press_debounced", want.press_debounced, out_press_debounced);
        check_field("trigger_source", want.trigger_source, out_trigger_source);
        check_field("trigger_total", want.trigger_total, out_trigger_total);
        check_field("trigger_stamp", want.trigger_stamp, out_trigger_stamp);
        check_field("health", want.health, out_health);
      end
    end
  end

  // receiver side: random stall bursts, or one long hold when a test asks
  initial begin : out_stall_gen
    int burst;
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_request(esl_pkg::op_t op, logic pressed, logic [2:0] src);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_button_pressed <= pressed;
    in_source <= src;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(latch_step(op, pressed, src));
    if (!calm && sender_idles && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // block must be idle; the spare index gets random data and must change nothing
  task automatic set_config(logic [15:0] deb, logic [15:0] rel, logic [15:0] stk);
    logic [1:0]  idx [4];
    logic [15:0] val [4];
    idx = '{esl_pkg::CFG_DEBOUNCE, esl_pkg::CFG_RELEASE, esl_pkg::CFG_STUCK, CFG_SPARE};
    val = '{deb, rel, stk, 16'($urandom)};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    debounce_lim = deb;
    release_lim  = rel;
    stuck_lim    = stk;
  endtask

  task automatic set_small_config();
    set_config(16'($urandom_range(0, 15)), 16'($urandom_range(0, 25)),
               16'($urandom_range(0, 30)));
  endtask

  // button held at a level that changes now and then, each change announced by
  // an edge event; the rest is ticks, triggers, reset requests and some noise
  task automatic run_random(int count);
    logic level;
    int   pick;
    level = 1'b0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        level = ~level;
        send_request(esl_pkg::OP_BUTTON_EDGE, level, 3'($urandom));
      end else if (pick < 62) begin
        send_request(esl_pkg::OP_TICK, level, 3'($urandom));
      end else if (pick < 72) begin
        send_request(esl_pkg::OP_TRIGGER, level, 3'($urandom));
      end else if (pick < 85) begin
        send_request(esl_pkg::OP_RESET_REQ, level, 3'($urandom));
      end else if (pick < 90) begin
        send_request(esl_pkg::OP_BUTTON_EDGE, level, 3'($urandom));  // bounce
      end else begin
        send_request(esl_pkg::op_t'($urandom_range(0, 3)), 1'($urandom), 3'($urandom));
      end
    end
  endtask

  task automatic test_directed_cases();
    send_request(esl_pkg::OP_TICK, 1'b0, esl_pkg::SRC_BUTTON);  // reset-value config
    wait_results_done();
    set_config(16'd2, 16'd6, 16'd3);
    send_request(esl_pkg::OP_RESET_REQ, 1'b0, esl_pkg::SRC_BUTTON);  // refused: not triggered
    send_request(esl_pkg::OP_BUTTON_EDGE, 1'b1, 3'd7);
    repeat (3) send_request(esl_pkg::OP_TICK, 1'b1, esl_pkg::SRC_BUTTON);  // trips
    send_request(esl_pkg::OP_RESET_REQ, 1'b1, 3'd3);  // refused: still pressed
    send_request(esl_pkg::OP_TRIGGER, 1'b1, 3'd7);     // retrigger while triggered
    send_request(esl_pkg::OP_TICK, 1'b0, 3'd1);
    send_request(esl_pkg::OP_RESET_REQ, 1'b0, 3'd6);
    repeat (8) send_request(esl_pkg::OP_TICK, 1'b0, 3'd4);  // health, then re-arm
    send_request(esl_pkg::OP_TRIGGER, 1'b0, 3'd5);
    send_request(esl_pkg::OP_RESET_REQ, 1'b0, esl_pkg::SRC_BUTTON);
    send_request(esl_pkg::OP_TRIGGER, 1'b0, 3'd2);     // trigger while pending
    wait_results_done();
  endtask

  task automatic test_random_small_delays();
    repeat (3) begin
      set_small_config();
      run_random(100);
      wait_results_done();
    end
  endtask

  task automatic test_zero_delays();
    set_config(16'd0, 16'd0, 16'd0);
    run_random(120);
    wait_results_done();
  endtask

  task automatic test_output_backpressure();
    set_small_config();
    sender_idles = 1'b0;
    hold_cycles = 300;
    run_random(40);
    wait_results_done();
    sender_idles = 1'b1;
  endtask

  task automatic test_max_delays();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(100);
    wait_results_done();
  endtask

  task automatic test_mixed_delays();
    set_config(16'hFFFF, 16'($urandom_range(0, 10)), 16'd0);
    run_random(50);
    wait_results_done();
    set_config(16'd0, 16'hFFFF, 16'($urandom_range(0, 20)));
    run_random(50);
    wait_results_done();
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    set_small_config();
    run_random(150);
    wait_results_done();
  endtask

  initial begin
    reset_latch_model();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_small_delays();
    test_zero_delays();
    test_output_backpressure();
    test_max_delays();
    test_mixed_delays();
    test_back_to_back();
    repeat (8) @(posedge clk);
    if (fails == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
